### rtl/rfa_pkg.sv
// rfa_pkg: shared types, codes and constants of the rational fraction ALU.
// No dependencies.
`default_nettype none
package rfa_pkg;

  localparam int unsigned WordBitsDefault = 32;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GCD_DEN, OP_GCD_RES, OP_GCD_NEXT,
    OP_DIV_XY, OP_DIV_QA, OP_DIV_QB, OP_DIV_RN, OP_DIV_RD,
    OP_SAVE_QA, OP_SAVE_QB, OP_SAVE_RN, OP_SAVE_RD,
    OP_MUL, OP_COMBINE
  } op_t;

  typedef enum logic [2:0] {
    MS_TA, MS_TB, MS_RD_ADD, MS_RN_MUL, MS_RD_MUL, MS_RN_DIV, MS_RD_DIV
  } mul_sel_t;

  typedef enum logic [1:0] {
    K_NORMAL, K_ZERO, K_ZERO_DEN
  } kind_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t msel;
    logic     out_load;
    kind_t    kind;
  } cmd_t;

  typedef struct packed {
    logic       div_idle;
    logic       y_zero;
    logic       rn_zero;
    logic       zd_err;
    logic [1:0] act;
  } stat_t;

endpackage
`default_nettype wire

### rtl/rfa_in_if.sv
// rfa_in_if: input channel carrying the operation and two fractions.
// Depends on nothing.
`default_nettype none
interface rfa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] num_a;
  logic signed [31:0] den_a;
  logic signed [31:0] num_b;
  logic signed [31:0] den_b;
  modport source (output valid, action, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, action, num_a, den_a, num_b, den_b, output ready);
endinterface
`default_nettype wire

### rtl/rfa_out_if.sv
// rfa_out_if: result channel carrying the reduced fraction and status.
// Depends on nothing.
`default_nettype none
interface rfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

### rtl/rfa_divider.sv
// rfa_divider: 64-bit restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module rfa_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             idle,
  output logic [63:0]      quo,
  output logic [63:0]      rem
);
  logic [6:0]  cnt;
  logic [63:0] acc;
  logic [63:0] d;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {acc, quo[63]};
  assign diff    = shifted - {1'b0, d};
  assign idle    = (cnt == 7'd0);
  assign rem     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 7'd0;
    end else if (start) begin
      cnt <= 7'd64;
    end else if (!idle) begin
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= 64'd0;
      quo <= dividend;
      d   <= divisor;
    end else if (!idle) begin
      if (!diff[64]) begin
        acc <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        acc <= shifted[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### rtl/rfa_datapath.sv
// rfa_datapath: operand registers, shared multiplier, GCD registers, result register.
// Depends on rfa_pkg and rfa_divider.
`default_nettype none
module rfa_datapath #(
  parameter int unsigned WORD_BITS = rfa_pkg::WordBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rfa_pkg::cmd_t      cmd,
  output rfa_pkg::stat_t          stat,
  input  wire logic [1:0]         in_action,
  input  wire logic [31:0]        in_num_a,
  input  wire logic [31:0]        in_den_a,
  input  wire logic [31:0]        in_num_b,
  input  wire logic [31:0]        in_den_b,
  output logic signed [31:0]      res_num,
  output logic [30:0]             res_den,
  output logic [1:0]              status
);
  localparam logic [63:0] Limit = 64'd1 << (WORD_BITS - 1);

  logic [1:0]  act;
  logic [31:0] na, da, nb, db, qa, qb;
  logic        sa, sb, rs;
  logic [63:0] x, y, rn, rd, ta, tb;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start, div_idle;
  logic [63:0] div_n, div_d, div_q, div_r;
  logic        sbe;
  logic        ovf;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  rfa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .idle(div_idle), .quo(div_q), .rem(div_r)
  );

  always_comb begin
    div_start = 1'b1;
    div_n     = x;
    div_d     = y;
    unique case (cmd.op)
      rfa_pkg::OP_DIV_XY: begin div_n = x;            div_d = y; end
      rfa_pkg::OP_DIV_QA: begin div_n = {32'd0, db};  div_d = x; end
      rfa_pkg::OP_DIV_QB: begin div_n = {32'd0, da};  div_d = x; end
      rfa_pkg::OP_DIV_RN: begin div_n = rn;           div_d = x; end
      rfa_pkg::OP_DIV_RD: begin div_n = rd;           div_d = x; end
      default:            div_start = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd.msel)
      rfa_pkg::MS_TA:     begin mul_a = na; mul_b = qa; end
      rfa_pkg::MS_TB:     begin mul_a = nb; mul_b = qb; end
      rfa_pkg::MS_RD_ADD: begin mul_a = qb; mul_b = db; end
      rfa_pkg::MS_RN_MUL: begin mul_a = na; mul_b = nb; end
      rfa_pkg::MS_RD_MUL: begin mul_a = da; mul_b = db; end
      rfa_pkg::MS_RN_DIV: begin mul_a = na; mul_b = db; end
      rfa_pkg::MS_RD_DIV: begin mul_a = da; mul_b = nb; end
      default:            begin mul_a = na; mul_b = nb; end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};
  assign sbe  = (act == rfa_pkg::ACT_SUB) ? ~sb : sb;
  assign ovf  = (rd > Limit - 64'd1) || (rs ? (rn > Limit) : (rn > Limit - 64'd1));

  assign stat.div_idle = div_idle;
  assign stat.y_zero   = (y == 64'd0);
  assign stat.rn_zero  = (rn == 64'd0);
  assign stat.zd_err   = (da == 32'd0) || (db == 32'd0) ||
                         ((act == rfa_pkg::ACT_DIV) && (nb == 32'd0));
  assign stat.act      = act;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rfa_pkg::OP_LOAD: begin
        act <= in_action;
        na  <= mag(in_num_a);
        da  <= mag(in_den_a);
        nb  <= mag(in_num_b);
        db  <= mag(in_den_b);
        sa  <= in_num_a[31] ^ in_den_a[31];
        sb  <= in_num_b[31] ^ in_den_b[31];
      end
      rfa_pkg::OP_GCD_DEN: begin x <= {32'd0, da}; y <= {32'd0, db}; end
      rfa_pkg::OP_GCD_RES: begin x <= rn; y <= rd; end
      rfa_pkg::OP_GCD_NEXT: begin x <= y; y <= div_r; end
      rfa_pkg::OP_SAVE_QA: qa <= div_q[31:0];
      rfa_pkg::OP_SAVE_QB: qb <= div_q[31:0];
      rfa_pkg::OP_SAVE_RN: rn <= div_q;
      rfa_pkg::OP_SAVE_RD: rd <= div_q;
      rfa_pkg::OP_MUL: begin
        unique case (cmd.msel)
          rfa_pkg::MS_TA:     ta <= prod;
          rfa_pkg::MS_TB:     tb <= prod;
          rfa_pkg::MS_RD_ADD: rd <= prod;
          rfa_pkg::MS_RN_MUL,
          rfa_pkg::MS_RN_DIV: begin rn <= prod; rs <= sa ^ sb; end
          default:            rd <= prod;
        endcase
      end
      rfa_pkg::OP_COMBINE: begin
        if (sa == sbe) begin
          rn <= ta + tb; rs <= sa;
        end else if (ta >= tb) begin
          rn <= ta - tb; rs <= sa;
        end else begin
          rn <= tb - ta; rs <= sbe;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.kind)
        rfa_pkg::K_ZERO_DEN: begin
          res_num <= '0; res_den <= '0; status <= rfa_pkg::ST_ZERO_DEN;
        end
        rfa_pkg::K_ZERO: begin
          res_num <= '0; res_den <= 31'd1; status <= rfa_pkg::ST_OK;
        end
        default: begin
          if (ovf) begin
            res_num <= '0; res_den <= '0; status <= rfa_pkg::ST_OVERFLOW;
          end else begin
            res_num <= rs ? (~rn[31:0] + 32'd1) : rn[31:0];
            res_den <= rd[30:0];
            status  <= rfa_pkg::ST_OK;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/rfa_ctrl.sv
// rfa_ctrl: sequencing state machine and result-valid handshake.
// Depends on rfa_pkg.
`default_nettype none
module rfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rfa_pkg::stat_t stat,
  output rfa_pkg::cmd_t       cmd
);
  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_CHECK = 16'h0002, S_M2    = 16'h0004, S_GTEST = 16'h0008,
    S_GWAIT = 16'h0010, S_QA    = 16'h0020, S_QBS   = 16'h0040, S_QB    = 16'h0080,
    S_MA    = 16'h0100, S_MB    = 16'h0200, S_MD    = 16'h0400, S_CMB   = 16'h0800,
    S_ZTEST = 16'h1000, S_QN    = 16'h2000, S_QDS   = 16'h4000, S_QD    = 16'h8000
  } state_t;

  state_t         state, state_next;
  logic           phase, phase_next;
  logic           wr_pend, wr_pend_next;
  rfa_pkg::kind_t kind, kind_next;
  logic           can_write;

  assign in_ready  = (state == S_IDLE) && !wr_pend;
  assign can_write = wr_pend && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    wr_pend_next = wr_pend;
    kind_next    = kind;
    cmd.op       = rfa_pkg::OP_NONE;
    cmd.msel     = rfa_pkg::MS_TA;
    cmd.out_load = can_write;
    cmd.kind     = kind;
    if (can_write) wr_pend_next = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = rfa_pkg::OP_LOAD; state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.zd_err) begin
          kind_next = rfa_pkg::K_ZERO_DEN; wr_pend_next = 1'b1; state_next = S_IDLE;
        end else if (stat.act == rfa_pkg::ACT_ADD || stat.act == rfa_pkg::ACT_SUB) begin
          cmd.op = rfa_pkg::OP_GCD_DEN; phase_next = 1'b0; state_next = S_GTEST;
        end else begin
          cmd.op   = rfa_pkg::OP_MUL;
          cmd.msel = (stat.act == rfa_pkg::ACT_MUL) ? rfa_pkg::MS_RN_MUL : rfa_pkg::MS_RN_DIV;
          state_next = S_M2;
        end
      end
      S_M2: begin
        cmd.op   = rfa_pkg::OP_MUL;
        cmd.msel = (stat.act == rfa_pkg::ACT_MUL) ? rfa_pkg::MS_RD_MUL : rfa_pkg::MS_RD_DIV;
        state_next = S_ZTEST;
      end
      S_GTEST: begin
        if (!stat.y_zero) begin
          cmd.op = rfa_pkg::OP_DIV_XY; state_next = S_GWAIT;
        end else if (!phase) begin
          cmd.op = rfa_pkg::OP_DIV_QA; state_next = S_QA;
        end else begin
          cmd.op = rfa_pkg::OP_DIV_RN; state_next = S_QN;
        end
      end
      S_GWAIT: if (stat.div_idle) begin
        cmd.op = rfa_pkg::OP_GCD_NEXT; state_next = S_GTEST;
      end
      S_QA: if (stat.div_idle) begin
        cmd.op = rfa_pkg::OP_SAVE_QA; state_next = S_QBS;
      end
      S_QBS: begin cmd.op = rfa_pkg::OP_DIV_QB; state_next = S_QB; end
      S_QB: if (stat.div_idle) begin
        cmd.op = rfa_pkg::OP_SAVE_QB; state_next = S_MA;
      end
      S_MA: begin cmd.op = rfa_pkg::OP_MUL; cmd.msel = rfa_pkg::MS_TA; state_next = S_MB; end
      S_MB: begin cmd.op = rfa_pkg::OP_MUL; cmd.msel = rfa_pkg::MS_TB; state_next = S_MD; end
      S_MD: begin
        cmd.op = rfa_pkg::OP_MUL; cmd.msel = rfa_pkg::MS_RD_ADD; state_next = S_CMB;
      end
      S_CMB: begin cmd.op = rfa_pkg::OP_COMBINE; state_next = S_ZTEST; end
      S_ZTEST: begin
        if (stat.rn_zero) begin
          kind_next = rfa_pkg::K_ZERO; wr_pend_next = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.op = rfa_pkg::OP_GCD_RES; phase_next = 1'b1; state_next = S_GTEST;
        end
      end
      S_QN: if (stat.div_idle) begin
        cmd.op = rfa_pkg::OP_SAVE_RN; state_next = S_QDS;
      end
      S_QDS: begin cmd.op = rfa_pkg::OP_DIV_RD; state_next = S_QD; end
      S_QD: if (stat.div_idle) begin
        cmd.op = rfa_pkg::OP_SAVE_RD; kind_next = rfa_pkg::K_NORMAL;
        wr_pend_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      wr_pend   <= 1'b0;
      kind      <= rfa_pkg::K_NORMAL;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      wr_pend <= wr_pend_next;
      kind    <= kind_next;
      if (can_write) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted transaction did not enter check");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rfa_pkg::OP_DIV_XY || cmd.op == rfa_pkg::OP_DIV_QA ||
     cmd.op == rfa_pkg::OP_DIV_QB || cmd.op == rfa_pkg::OP_DIV_RN ||
     cmd.op == rfa_pkg::OP_DIV_RD) |-> stat.div_idle)
    else $error("divider started while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while stalled");
endmodule
`default_nettype wire

### rtl/rational_fraction_alu_core.sv
// rational_fraction_alu_core: top level of the rational fraction ALU.
// Depends on rfa_pkg, rfa_in_if, rfa_out_if, rfa_ctrl, rfa_datapath.
//
// Input channel in_ch carries action (add, subtract, multiply, divide) and two
// signed fractions; output channel out_ch returns the result reduced to lowest
// terms with the sign on res_num, plus a status (ok, zero denominator,
// overflow). Both use valid/ready; a transaction moves when both are high.
// One item is worked on at a time. Every remainder and every division by the
// GCD goes through one shared 64-bit divider that produces one quotient bit
// per cycle, so the number of Euclid steps sets how long a result takes. Add
// and subtract run Euclid on the denominators and then on the result;
// multiply and divide only on the result. A zero denominator needs no division.
// The finished result sits in an output register; a new transaction is taken
// while it waits, and a stalled receiver holds the next result pending.
// Synchronous reset returns the controller to idle and drops out_ch.valid.
`default_nettype none
module rational_fraction_alu_core #(
  parameter int unsigned WORD_BITS = rfa_pkg::WordBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);
  rfa_pkg::cmd_t  cmd;
  rfa_pkg::stat_t stat;

  rfa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  rfa_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_action(in_ch.action),
    .in_num_a(in_ch.num_a), .in_den_a(in_ch.den_a),
    .in_num_b(in_ch.num_b), .in_den_b(in_ch.den_b),
    .res_num(out_ch.res_num), .res_den(out_ch.res_den), .status(out_ch.status)
  );
endmodule
`default_nettype wire
